>>> hdl/fpa_pkg.sv
// Shared types, operation codes and saturation helper for the fixed-point ALU.
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int WORD_BITS = 32;
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int DIV_STEPS = WORD_BITS;

   localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   typedef logic [3:0] kind_type;

   localparam kind_type KIND_ADD      = 4'd0;
   localparam kind_type KIND_SUB      = 4'd1;
   localparam kind_type KIND_MUL      = 4'd2;
   localparam kind_type KIND_DIV      = 4'd3;
   localparam kind_type KIND_GT       = 4'd4;
   localparam kind_type KIND_LT       = 4'd5;
   localparam kind_type KIND_GE       = 4'd6;
   localparam kind_type KIND_LE       = 4'd7;
   localparam kind_type KIND_EQ       = 4'd8;
   localparam kind_type KIND_NE       = 4'd9;
   localparam kind_type KIND_MIN      = 4'd10;
   localparam kind_type KIND_MAX      = 4'd11;
   localparam kind_type KIND_INC      = 4'd12;
   localparam kind_type KIND_DEC      = 4'd13;
   localparam kind_type KIND_TO_INT   = 4'd14;
   localparam kind_type KIND_FROM_INT = 4'd15;

   typedef struct packed {
      logic                 sat;
      logic [WORD_BITS-1:0] val;
   } clamp_type;

   // state carried through the divider chain; res/cmp/sat hold finished non-div results
   typedef struct packed {
      kind_type             kind;
      logic                 neg;
      logic                 dz;
      logic                 cmp;
      logic                 sat;
      logic [WORD_BITS-1:0] res;
      logic                 big;
      logic [WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0] dvs;
      logic [WORD_BITS-1:0] num;
      logic [WORD_BITS-1:0] quo;
   } div_type;

   // apply sign to a magnitude and clamp to the signed word range
   function automatic clamp_type sat_mag(input logic [PROD_BITS-1:0] mag, input logic neg);
      clamp_type c;
      c.sat = 1'b0;
      c.val = '0;
      if (!neg && (mag > PROD_BITS'(WORD_MAX))) begin
         c.sat = 1'b1;
         c.val = WORD_MAX;
      end else if (neg && (mag > PROD_BITS'(WORD_MIN))) begin
         c.sat = 1'b1;
         c.val = WORD_MIN;
      end else if (neg) begin
         c.val = '0 - mag[WORD_BITS-1:0];
      end else begin
         c.val = mag[WORD_BITS-1:0];
      end
      return c;
   endfunction

endpackage

>>> hdl/fpa_front.sv
// Front stages: decode and simple ops, multiply, product rounding and divider setup.
module fpa_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  fpa_pkg::kind_type            in_kind,
   input  logic signed [fpa_pkg::WORD_BITS-1:0] in_a,
   input  logic signed [fpa_pkg::WORD_BITS-1:0] in_b,
   output logic                         out_valid,
   output fpa_pkg::div_type             out_st
);
   import fpa_pkg::*;

   typedef struct packed {
      kind_type             kind;
      logic                 neg;
      logic                 dz;
      logic                 cmp;
      logic                 sat;
      logic [WORD_BITS-1:0] res;
      logic [WORD_BITS-1:0] ma;
      logic [WORD_BITS-1:0] mb;
   } front_type;

   localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(1) << (FRAC_BITS - 1);

   function automatic clamp_type clamp_wide(input logic [WORD_BITS:0] v);
      clamp_type c;
      c.sat = (v[WORD_BITS] != v[WORD_BITS-1]);
      c.val = c.sat ? (v[WORD_BITS] ? WORD_MIN : WORD_MAX) : v[WORD_BITS-1:0];
      return c;
   endfunction

   front_type            st_a_in, st_a_ff, st_b_ff;
   logic [PROD_BITS-1:0] prod_in, prod_ff;
   div_type              st_c_in, st_c_ff;
   logic                 vld_a_ff, vld_b_ff, vld_c_ff;

   logic [WORD_BITS:0]   ext_a, ext_b;
   logic                 lt, eq;
   clamp_type            c_add, c_sub, c_inc, c_dec;
   logic [FRAC_BITS:0]   top_bits;
   logic [PROD_BITS-1:0] rnd;
   clamp_type            c_mul;

   assign ext_a = {in_a[WORD_BITS-1], in_a};
   assign ext_b = {in_b[WORD_BITS-1], in_b};
   assign lt    = in_a < in_b;
   assign eq    = in_a == in_b;
   assign c_add = clamp_wide(ext_a + ext_b);
   assign c_sub = clamp_wide(ext_a - ext_b);
   assign c_inc = clamp_wide(ext_a + (WORD_BITS+1)'(1));
   assign c_dec = clamp_wide(ext_a - (WORD_BITS+1)'(1));
   assign top_bits = in_a[WORD_BITS-1 -: (FRAC_BITS+1)];

   always_comb begin
      st_a_in.kind = in_kind;
      st_a_in.neg  = in_a[WORD_BITS-1] ^ in_b[WORD_BITS-1];
      st_a_in.dz   = (in_kind == KIND_DIV) && (in_b == '0);
      st_a_in.ma   = in_a[WORD_BITS-1] ? ('0 - in_a) : in_a;
      st_a_in.mb   = in_b[WORD_BITS-1] ? ('0 - in_b) : in_b;
      st_a_in.cmp  = 1'b0;
      st_a_in.sat  = 1'b0;
      st_a_in.res  = '0;
      unique case (in_kind)
         KIND_ADD: begin
            st_a_in.res = c_add.val;
            st_a_in.sat = c_add.sat;
         end
         KIND_SUB: begin
            st_a_in.res = c_sub.val;
            st_a_in.sat = c_sub.sat;
         end
         KIND_GT: st_a_in.cmp = !lt && !eq;
         KIND_LT: st_a_in.cmp = lt;
         KIND_GE: st_a_in.cmp = !lt;
         KIND_LE: st_a_in.cmp = lt || eq;
         KIND_EQ: st_a_in.cmp = eq;
         KIND_NE: st_a_in.cmp = !eq;
         KIND_MIN: st_a_in.res = lt ? in_a : in_b;
         KIND_MAX: st_a_in.res = (!lt && !eq) ? in_a : in_b;
         KIND_INC: begin
            st_a_in.res = c_inc.val;
            st_a_in.sat = c_inc.sat;
         end
         KIND_DEC: begin
            st_a_in.res = c_dec.val;
            st_a_in.sat = c_dec.sat;
         end
         KIND_TO_INT: st_a_in.res = in_a >>> FRAC_BITS;
         KIND_FROM_INT: begin
            if ((top_bits == '0) || (top_bits == '1)) begin
               st_a_in.res = in_a << FRAC_BITS;
            end else begin
               st_a_in.sat = 1'b1;
               st_a_in.res = in_a[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
            end
         end
         default: ; // mul and div finish in later stages
      endcase
   end

   assign prod_in = st_a_ff.ma * st_a_ff.mb;
   assign rnd     = (prod_ff + HALF) >> FRAC_BITS;
   assign c_mul   = sat_mag(rnd, st_b_ff.neg);

   always_comb begin
      st_c_in.kind = st_b_ff.kind;
      st_c_in.neg  = st_b_ff.neg;
      st_c_in.dz   = st_b_ff.dz;
      st_c_in.cmp  = st_b_ff.cmp;
      st_c_in.sat  = st_b_ff.sat;
      st_c_in.res  = st_b_ff.res;
      if (st_b_ff.kind == KIND_MUL) begin
         st_c_in.sat = c_mul.sat;
         st_c_in.res = c_mul.val;
      end
      // numerator is |a| << FRAC_BITS; the top FRAC_BITS bits seed the remainder
      st_c_in.rem = WORD_BITS'(st_b_ff.ma[WORD_BITS-1 -: FRAC_BITS]);
      st_c_in.num = {st_b_ff.ma[WORD_BITS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
      st_c_in.dvs = st_b_ff.mb;
      st_c_in.quo = '0;
      // quotient would not fit in WORD_BITS bits
      st_c_in.big = WORD_BITS'(st_b_ff.ma[WORD_BITS-1 -: FRAC_BITS]) >= st_b_ff.mb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_a_ff <= st_a_in;
         st_b_ff <= st_a_ff;
         prod_ff <= prod_in;
         st_c_ff <= st_c_in;
      end
   end

   assign out_valid = vld_c_ff;
   assign out_st    = st_c_ff;

endmodule

>>> hdl/fpa_div_step.sv
// One registered step of the restoring divider: one quotient bit per stage.
module fpa_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             adv,
   input  logic             in_valid,
   input  fpa_pkg::div_type in_st,
   output logic             out_valid,
   output fpa_pkg::div_type out_st
);
   import fpa_pkg::*;

   logic [WORD_BITS:0] trial, diff;
   logic               ge;
   div_type            st_in, st_ff;
   logic               vld_ff;

   assign trial = {in_st.rem, in_st.num[WORD_BITS-1]};
   assign diff  = trial - {1'b0, in_st.dvs};
   assign ge    = trial >= {1'b0, in_st.dvs};

   always_comb begin
      st_in     = in_st;
      st_in.rem = ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
      st_in.num = {in_st.num[WORD_BITS-2:0], 1'b0};
      st_in.quo = {in_st.quo[WORD_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = vld_ff;
   assign out_st    = st_ff;

endmodule

>>> hdl/fpa_back.sv
// Back stage: quotient rounding and clamping, result select and output register.
module fpa_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  fpa_pkg::div_type             in_st,
   output logic                         out_valid,
   output logic [fpa_pkg::WORD_BITS-1:0] out_res,
   output logic                         out_cmp,
   output logic                         out_sat,
   output logic                         out_dz
);
   import fpa_pkg::*;

   logic               round_up;
   logic [WORD_BITS:0] q_round;
   clamp_type          c_div;
   logic [WORD_BITS-1:0] res_in, res_ff;
   logic               sat_in, sat_ff, cmp_ff, dz_ff, vld_ff;

   // round half away from zero: bump when twice the remainder reaches the divisor
   assign round_up = {in_st.rem, 1'b0} >= {1'b0, in_st.dvs};
   assign q_round  = {1'b0, in_st.quo} + (WORD_BITS+1)'(round_up);
   assign c_div    = sat_mag(PROD_BITS'(q_round), in_st.neg);

   always_comb begin
      res_in = in_st.res;
      sat_in = in_st.sat;
      if (in_st.kind == KIND_DIV) begin
         if (in_st.dz) begin
            res_in = '0;
            sat_in = 1'b0;
         end else if (in_st.big) begin
            res_in = in_st.neg ? WORD_MIN : WORD_MAX;
            sat_in = 1'b1;
         end else begin
            res_in = c_div.val;
            sat_in = c_div.sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
         cmp_ff <= in_st.cmp;
         dz_ff  <= in_st.dz;
      end
   end

   assign out_valid = vld_ff;
   assign out_res   = res_ff;
   assign out_cmp   = cmp_ff;
   assign out_sat   = sat_ff;
   assign out_dz    = dz_ff;

endmodule

>>> hdl/fixed_point_alu.sv
// Q24.8 fixed-point ALU top level: pipeline of front stages, divider chain and output stage.
// Takes one item per clock while req_stall is low and returns results in order; the 32
// one-bit restoring divider stages sit between the front stages and the output stage,
// and every kind travels the same path so order is kept. A stalled result holds in the
// output register and freezes the whole pipeline, so req_stall follows rsp_stall while a
// result is waiting (and is high during reset). Products and quotients round half away
// from zero, all arithmetic results saturate to the 32-bit range, and divide by zero
// returns 0 with divide_by_zero set.
module fixed_point_alu (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  fpa_pkg::kind_type                    req_kind,
   input  logic signed [fpa_pkg::WORD_BITS-1:0] req_operand_a,
   input  logic signed [fpa_pkg::WORD_BITS-1:0] req_operand_b,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fpa_pkg::WORD_BITS-1:0] rsp_result_raw,
   output logic                                 rsp_compare_true,
   output logic                                 rsp_saturated,
   output logic                                 rsp_divide_by_zero
);
   import fpa_pkg::*;

   logic                 adv;
   logic                 vld_chain [0:DIV_STEPS];
   div_type              st_chain  [0:DIV_STEPS];
   logic [WORD_BITS-1:0] res_out;

   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = reset || !adv;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid && !req_stall),
      .in_kind   (req_kind),
      .in_a      (req_operand_a),
      .in_b      (req_operand_b),
      .out_valid (vld_chain[0]),
      .out_st    (st_chain[0])
   );

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      fpa_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .adv       (adv),
         .in_valid  (vld_chain[i]),
         .in_st     (st_chain[i]),
         .out_valid (vld_chain[i+1]),
         .out_st    (st_chain[i+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_chain[DIV_STEPS]),
      .in_st     (st_chain[DIV_STEPS]),
      .out_valid (rsp_valid),
      .out_res   (res_out),
      .out_cmp   (rsp_compare_true),
      .out_sat   (rsp_saturated),
      .out_dz    (rsp_divide_by_zero)
   );

   assign rsp_result_raw = res_out;

endmodule

>>> hdl/fpa_checker.sv
// Port-level checker for the fixed-point ALU, bound to the top level.
module fpa_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [fpa_pkg::WORD_BITS-1:0] rsp_result_raw,
   input logic                                 rsp_compare_true,
   input logic                                 rsp_saturated,
   input logic                                 rsp_divide_by_zero
);
   import fpa_pkg::*;

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_raw)
         && $stable(rsp_compare_true) && $stable(rsp_saturated)
         && $stable(rsp_divide_by_zero))
      else $error("result item changed while stalled");

   // input is only held back while a result waits
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a waiting result");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_result_raw == '0 && !rsp_saturated
         && !rsp_compare_true)
      else $error("divide by zero item carries a value or flags");

   a_cmp_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> rsp_result_raw == '0 && !rsp_saturated)
      else $error("comparison item carries a value");

   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |-> rsp_result_raw == WORD_MAX || rsp_result_raw == WORD_MIN)
      else $error("saturated item not at a limit");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_raw     (rsp_result_raw),
   .rsp_compare_true   (rsp_compare_true),
   .rsp_saturated      (rsp_saturated),
   .rsp_divide_by_zero (rsp_divide_by_zero)
);

>>> test/fixed_point_alu_tb.sv
// Testbench for the Q24.8 fixed-point ALU: directed corners, random traffic, scoreboard.
`timescale 1ns / 100ps

module fixed_point_alu_tb;
   import fpa_pkg::*;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      kind_type kind;
      word_type a;
      word_type b;
      word_type raw;
      logic     cmp;
      logic     sat;
      logic     dz;
   } alu_outcome_type;

   localparam longint WORD_HI = (longint'(1) << (WORD_BITS - 1)) - 1;
   localparam longint WORD_LO = -WORD_HI - 1;
   localparam int     MAX_SHOWN = 10;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   kind_type req_kind = KIND_ADD;
   word_type req_operand_a = '0;
   word_type req_operand_b = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_result_raw;
   logic     rsp_compare_true;
   logic     rsp_saturated;
   logic     rsp_divide_by_zero;

   alu_outcome_type pending_outcomes[$];
   bit              idle_gaps = 1'b1;
   int              items_sent = 0;
   int              results_checked = 0;
   int              mismatches = 0;
   int              saturated_seen = 0;
   int              div_zero_seen = 0;
   int              true_compares = 0;

   fixed_point_alu uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_operand_a      (req_operand_a),
      .req_operand_b      (req_operand_b),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_raw     (rsp_result_raw),
      .rsp_compare_true   (rsp_compare_true),
      .rsp_saturated      (rsp_saturated),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200_000;
      $display("Timeout: %0d results still outstanding", pending_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic word_type clamp_word(longint v, output logic sat);
      sat = 1'b0;
      if (v > WORD_HI) begin
         sat = 1'b1;
         return WORD_MAX;
      end
      if (v < WORD_LO) begin
         sat = 1'b1;
         return WORD_MIN;
      end
      return word_type'(v);
   endfunction

   // exact integer model; products and quotients round half away from zero
   function automatic alu_outcome_type compute_outcome(kind_type kind, word_type a,
                                                       word_type b);
      alu_outcome_type o;
      longint sa, sb;
      longint unsigned ma, mb, mag;
      logic neg;
      o = '0;
      o.kind = kind;
      o.a = a;
      o.b = b;
      sa = a;
      sb = b;
      ma = (sa < 0) ? -sa : sa;
      mb = (sb < 0) ? -sb : sb;
      neg = (sa < 0) != (sb < 0);
      case (kind)
         KIND_ADD: o.raw = clamp_word(sa + sb, o.sat);
         KIND_SUB: o.raw = clamp_word(sa - sb, o.sat);
         KIND_MUL: begin
            mag = ma * mb;
            mag = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            o.raw = clamp_word(neg ? -longint'(mag) : longint'(mag), o.sat);
         end
         KIND_DIV: begin
            if (sb == 0) begin
               o.dz = 1'b1;
            end else begin
               mag = ma << FRAC_BITS;
               mag = (2 * mag + mb) / (2 * mb);
               o.raw = clamp_word(neg ? -longint'(mag) : longint'(mag), o.sat);
            end
         end
         KIND_GT: o.cmp = sa > sb;
         KIND_LT: o.cmp = sa < sb;
         KIND_GE: o.cmp = sa >= sb;
         KIND_LE: o.cmp = sa <= sb;
         KIND_EQ: o.cmp = sa == sb;
         KIND_NE: o.cmp = sa != sb;
         KIND_MIN: o.raw = (sa < sb) ? a : b;
         KIND_MAX: o.raw = (sa > sb) ? a : b;
         KIND_INC: o.raw = clamp_word(sa + 1, o.sat);
         KIND_DEC: o.raw = clamp_word(sa - 1, o.sat);
         KIND_TO_INT: o.raw = a >>> FRAC_BITS;
         KIND_FROM_INT: begin
            mag = ma << FRAC_BITS;
            o.raw = clamp_word((sa < 0) ? -longint'(mag) : longint'(mag), o.sat);
         end
         default: o = o;
      endcase
      return o;
   endfunction

   // mix of corners, full-range words and magnitudes that keep mul/div in range
   function automatic word_type pick_operand();
      word_type v;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 7))
               0: v = WORD_MAX;
               1: v = WORD_MIN;
               2: v = '0;
               3: v = 1;
               4: v = -1;
               5: v = 256;
               6: v = -256;
               default: v = 128;
            endcase
         end
         1, 2, 3: v = $urandom;
         4, 5: begin
            v = $urandom_range(0, 32'h1_FFFF);
            v = v - 32'h1_0000;
         end
         6, 7: begin
            v = $urandom;
            v = v >>> $urandom_range(4, 24);
         end
         8: v = $urandom_range(0, 1) ? WORD_MAX - $urandom_range(0, 300)
                                     : WORD_MIN + $urandom_range(0, 300);
         default: begin
            v = word_type'(1) << $urandom_range(0, 30);
            if ($urandom_range(0, 1))
               v = -v;
         end
      endcase
      return v;
   endfunction

   task automatic issue_op(kind_type kind, word_type a, word_type b);
      while (idle_gaps && $urandom_range(0, 99) < 16) begin
         req_valid <= 1'b0;
         req_kind <= kind_type'($urandom_range(KIND_ADD, KIND_FROM_INT));
         req_operand_a <= $urandom;
         req_operand_b <= $urandom;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_operand_a <= a;
      req_operand_b <= b;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      pending_outcomes.push_back(compute_outcome(kind, a, b));
      items_sent++;
   endtask

   always @(posedge clock) begin : result_check
      alu_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN)
               $display("Unexpected result raw=%0d at %0t", rsp_result_raw, $realtime);
         end else begin
            want = pending_outcomes.pop_front();
            results_checked++;
            saturated_seen += want.sat;
            div_zero_seen += want.dz;
            true_compares += want.cmp;
            if (rsp_result_raw !== want.raw || rsp_compare_true !== want.cmp ||
                rsp_saturated !== want.sat || rsp_divide_by_zero !== want.dz) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display({"Mismatch kind=%0d a=%0d b=%0d: expected raw=%0d cmp=%b sat=%b ",
                            "dz=%b, got raw=%0d cmp=%b sat=%b dz=%b"},
                           want.kind, want.a, want.b, want.raw, want.cmp, want.sat,
                           want.dz, rsp_result_raw, rsp_compare_true, rsp_saturated,
                           rsp_divide_by_zero);
            end
         end
      end
      rsp_stall <= idle_gaps && ($urandom_range(0, 99) < 16);
   end

   // saturation at both limits, rounding of half values, divide by zero
   task automatic test_arith_limits();
      issue_op(KIND_ADD, WORD_MAX, 1);
      issue_op(KIND_ADD, WORD_MIN, -1);
      issue_op(KIND_SUB, WORD_MIN, 1);
      issue_op(KIND_MUL, WORD_MAX, WORD_MAX);
      issue_op(KIND_MUL, 1, 128);
      issue_op(KIND_MUL, -1, 128);
      issue_op(KIND_DIV, 5, 0);
      issue_op(KIND_DIV, WORD_MIN, 1);
      issue_op(KIND_DIV, 1, 512);
      issue_op(KIND_DIV, -1, 512);
      issue_op(KIND_INC, WORD_MAX, 0);
      issue_op(KIND_DEC, WORD_MIN, 0);
      issue_op(KIND_FROM_INT, WORD_MAX, 0);
      issue_op(KIND_FROM_INT, -1, WORD_MAX);
   endtask

   task automatic test_compare_select();
      issue_op(KIND_GT, WORD_MAX, WORD_MIN);
      issue_op(KIND_LT, WORD_MAX, WORD_MIN);
      issue_op(KIND_GE, WORD_MIN, WORD_MIN);
      issue_op(KIND_LE, WORD_MAX, WORD_MAX);
      issue_op(KIND_EQ, -1, -1);
      issue_op(KIND_NE, 0, WORD_MIN);
      issue_op(KIND_MIN, WORD_MIN, WORD_MAX);
      issue_op(KIND_MAX, WORD_MIN, WORD_MAX);
   endtask

   // to_int floors toward minus infinity
   task automatic test_int_conversion();
      issue_op(KIND_TO_INT, -1, 0);
      issue_op(KIND_TO_INT, WORD_MIN, 0);
      issue_op(KIND_TO_INT, WORD_MAX, 0);
   endtask

   task automatic test_random_mix(int count);
      kind_type kind;
      word_type a, b;
      repeat (count) begin
         kind = kind_type'($urandom_range(KIND_ADD, KIND_FROM_INT));
         a = pick_operand();
         b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
         issue_op(kind, a, b);
      end
   endtask

   task automatic test_random_back_to_back(int count);
      idle_gaps = 1'b0;
      test_random_mix(count);
      idle_gaps = 1'b1;
   endtask

   task automatic test_random_mul_div(int count);
      kind_type kind;
      word_type b;
      repeat (count) begin
         kind = $urandom_range(0, 1) ? KIND_MUL : KIND_DIV;
         b = ($urandom_range(0, 19) == 0) ? '0 : pick_operand();
         issue_op(kind, pick_operand(), b);
      end
   endtask

   initial begin
      int waited;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_arith_limits();
      test_compare_select();
      test_int_conversion();
      test_random_mix(900);
      test_random_back_to_back(450);
      test_random_mul_div(450);
      req_valid <= 1'b0;

      waited = 0;
      while (pending_outcomes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $display("%0d expected results never arrived", pending_outcomes.size());
         mismatches++;
      end

      $display("Sent %0d items over all 16 kinds, checked %0d results, %0d mismatches",
               items_sent, results_checked, mismatches);
      $display("Saturated %0d, divide by zero %0d, true comparisons %0d",
               saturated_seen, div_zero_seen, true_compares);
      if (mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
